>>> hdl/pba_pkg.sv
// shared types and codes for the page bitmap allocator
`timescale 1ns / 1ps

package pba_pkg;

    // widths of the fixed request and result fields
    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned BIT_W     = 5;
    localparam int unsigned REQ_W     = 2;
    localparam int unsigned IDX_W     = 9;
    localparam int unsigned CNT_W     = 10;
    localparam int unsigned STAT_W    = 2;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_GIVEN = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFREE = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE  = 2'd2;
    localparam logic [STAT_W-1:0] ST_STATE  = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_RD,
        S_LOAD,
        S_ALLOC,
        S_GIVEN,
        S_FREE,
        S_DONE
    } t_state;

    // answer of the lowest-zero search over one bitmap word
    typedef struct packed {
        logic                 found;
        logic [BIT_W-1:0]     bit_idx;
        logic [WORD_BITS-1:0] onehot;
    } t_find;

endpackage

>>> hdl/pba_find_zero.sv
// lowest clear bit search over one 32-bit bitmap word
`timescale 1ns / 1ps

module pba_find_zero (
    input  logic [pba_pkg::WORD_BITS-1:0] i_word,
    output pba_pkg::t_find                o_res
);

    logic [pba_pkg::WORD_BITS-1:0] inv;
    logic [pba_pkg::WORD_BITS-1:0] low;
    logic [pba_pkg::BIT_W-1:0]     enc;

    // isolate the lowest free bit
    assign inv = ~i_word;
    assign low = inv & (~inv + pba_pkg::WORD_BITS'(1));

    // encode the one-hot position
    always_comb begin
        enc = '0;
        for (int b = 0; b < pba_pkg::WORD_BITS; b++) begin
            if (low[b]) begin
                enc = enc | pba_pkg::BIT_W'(b);
            end
        end
    end

    assign o_res.found   = |inv;
    assign o_res.bit_idx = enc;
    assign o_res.onehot  = low;

endmodule

>>> hdl/page_bitmap_allocator.sv
// page bitmap allocator top level: sequencer, bitmap memory and result registers
`timescale 1ns / 1ps

// One bit per page, BITMAP_WORDS words of 32 bits, lowest RESERVED_PAGES pages (at most
// 32) always taken. A request is taken when start is high and busy is low; busy stays
// high until the single result beat has been shown on the o_ result ports for one cycle
// with o_strobe high. The receiver cannot stall that beat. Timing is set by the bitmap
// memory's single read port and the single lowest-zero search. Allocate-count reads the
// bitmap words in turn, takes free pages from each word one by one and moves on to the
// next word when that word has none left; free examines pages one by one from the given
// page, reading each new word that it enters; allocate-given reads the page's word once
// and tests its bit; a rejected request goes straight to its result beat. Clear sweeps
// the memory word by word before its result beat. After reset the same sweep runs
// with busy high before the first request is taken.
module page_bitmap_allocator #(
    parameter int unsigned BITMAP_WORDS   = 16,
    parameter int unsigned RESERVED_PAGES = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [pba_pkg::REQ_W-1:0]    i_req_type,
    input  logic [pba_pkg::IDX_W-1:0]    i_page_index,
    input  logic [pba_pkg::CNT_W-1:0]    i_page_count,
    output logic                         o_strobe,
    output logic [pba_pkg::STAT_W-1:0]   o_status,
    output logic [pba_pkg::IDX_W-1:0]    o_first_page,
    output logic [pba_pkg::CNT_W-1:0]    o_pages_done
);

    localparam int unsigned TOTAL   = BITMAP_WORDS * pba_pkg::WORD_BITS;
    localparam int unsigned WI      = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int unsigned PGW_RAW = $clog2(TOTAL + 1);
    localparam int unsigned PGW     = (PGW_RAW > 11) ? PGW_RAW : 11;
    localparam logic [pba_pkg::WORD_BITS-1:0] RES_MASK =
        (RESERVED_PAGES >= 32) ? {pba_pkg::WORD_BITS{1'b1}} :
        ((pba_pkg::WORD_BITS'(1) << RESERVED_PAGES) - pba_pkg::WORD_BITS'(1));
    localparam logic [PGW-1:0] TOTAL_PG = PGW'(TOTAL);
    localparam logic [PGW-1:0] RES_PG   = PGW'(RESERVED_PAGES);
    localparam logic [WI-1:0]  LAST_W   = WI'(BITMAP_WORDS - 1);

    pba_pkg::t_state r_state, n_state;

    logic [pba_pkg::REQ_W-1:0]     r_req,    n_req;
    logic [WI-1:0]                 r_widx,   n_widx;
    logic [PGW-1:0]                r_page,   n_page;
    logic [pba_pkg::CNT_W-1:0]     r_left,   n_left;
    logic [pba_pkg::CNT_W-1:0]     r_done,   n_done;
    logic [pba_pkg::IDX_W-1:0]     r_first,  n_first;
    logic [pba_pkg::STAT_W-1:0]    r_status, n_status;
    logic [pba_pkg::WORD_BITS-1:0] r_word,   n_word;
    logic                          r_clr_req, n_clr_req;

    logic [pba_pkg::WORD_BITS-1:0] mem [BITMAP_WORDS];
    logic [pba_pkg::WORD_BITS-1:0] r_rdata;
    logic                          mem_we;
    logic [WI-1:0]                 mem_wa;
    logic [pba_pkg::WORD_BITS-1:0] mem_wd;

    pba_pkg::t_find                fz;
    logic                          accept;
    logic                          last_one;
    logic                          last_word;
    logic [PGW-1:0]                alloc_page;
    logic [PGW-1:0]                req_page;
    logic [PGW-1:0]                next_page;
    logic [pba_pkg::WORD_BITS-1:0] page_bit;
    logic                          page_set;
    logic                          word_end;
    logic                          req_in_range;
    logic                          free_in_range;

    // lowest-zero search unit, used by allocate-count only
    pba_find_zero u_find (
        .i_word (r_word),
        .o_res  (fz)
    );

    // common decode
    assign accept        = start && !busy;
    assign last_one      = (r_left == pba_pkg::CNT_W'(1));
    assign last_word     = (r_widx == LAST_W);
    assign alloc_page    = (PGW'(r_widx) << pba_pkg::BIT_W) | PGW'(fz.bit_idx);
    assign req_page      = PGW'(i_page_index);
    assign next_page     = r_page + PGW'(1);
    assign page_bit      = pba_pkg::WORD_BITS'(1) << r_page[pba_pkg::BIT_W-1:0];
    assign page_set      = |(r_word & page_bit);
    assign word_end      = (r_page[pba_pkg::BIT_W-1:0] == {pba_pkg::BIT_W{1'b1}});
    assign req_in_range  = (req_page < TOTAL_PG);
    assign free_in_range = req_in_range && (req_page >= RES_PG);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pba_pkg::S_INIT: begin
                if (last_word) begin
                    n_state = r_clr_req ? pba_pkg::S_DONE : pba_pkg::S_IDLE;
                end
            end
            pba_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_req_type)
                        pba_pkg::REQ_ALLOC: begin
                            n_state = (i_page_count == '0) ? pba_pkg::S_DONE : pba_pkg::S_RD;
                        end
                        pba_pkg::REQ_GIVEN: begin
                            n_state = req_in_range ? pba_pkg::S_RD : pba_pkg::S_DONE;
                        end
                        pba_pkg::REQ_FREE: begin
                            n_state = ((i_page_count != '0) && free_in_range) ?
                                      pba_pkg::S_RD : pba_pkg::S_DONE;
                        end
                        default: begin
                            n_state = pba_pkg::S_INIT;
                        end
                    endcase
                end
            end
            pba_pkg::S_RD: begin
                n_state = pba_pkg::S_LOAD;
            end
            pba_pkg::S_LOAD: begin
                case (r_req)
                    pba_pkg::REQ_ALLOC: n_state = pba_pkg::S_ALLOC;
                    pba_pkg::REQ_GIVEN: n_state = pba_pkg::S_GIVEN;
                    default:            n_state = pba_pkg::S_FREE;
                endcase
            end
            pba_pkg::S_ALLOC: begin
                if (fz.found) begin
                    if (last_one) begin
                        n_state = pba_pkg::S_DONE;
                    end
                end else begin
                    n_state = last_word ? pba_pkg::S_DONE : pba_pkg::S_RD;
                end
            end
            pba_pkg::S_GIVEN: begin
                n_state = pba_pkg::S_DONE;
            end
            pba_pkg::S_FREE: begin
                if (!page_set || last_one) begin
                    n_state = pba_pkg::S_DONE;
                end else if (word_end) begin
                    n_state = (next_page >= TOTAL_PG) ? pba_pkg::S_DONE : pba_pkg::S_RD;
                end
            end
            pba_pkg::S_DONE: begin
                n_state = pba_pkg::S_IDLE;
            end
            default: begin
                n_state = pba_pkg::S_IDLE;
            end
        endcase
    end

    // outputs and memory write port
    always_comb begin
        busy     = 1'b1;
        o_strobe = 1'b0;
        mem_we   = 1'b0;
        mem_wa   = r_widx;
        mem_wd   = r_word;
        case (r_state)
            pba_pkg::S_INIT: begin
                mem_we = 1'b1;
                mem_wd = (r_widx == '0) ? RES_MASK : '0;
            end
            pba_pkg::S_IDLE: begin
                busy = 1'b0;
            end
            pba_pkg::S_ALLOC: begin
                mem_we = !fz.found || last_one;
                mem_wd = r_word | (fz.found ? fz.onehot : '0);
            end
            pba_pkg::S_GIVEN: begin
                mem_we = !page_set;
                mem_wd = r_word | page_bit;
            end
            pba_pkg::S_FREE: begin
                mem_we = !page_set || last_one || word_end;
                mem_wd = r_word & ~(page_set ? page_bit : '0);
            end
            pba_pkg::S_DONE: begin
                o_strobe = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    assign o_status     = r_status;
    assign o_first_page = r_first;
    assign o_pages_done = r_done;

    // datapath next values
    always_comb begin
        n_req     = r_req;
        n_widx    = r_widx;
        n_page    = r_page;
        n_left    = r_left;
        n_done    = r_done;
        n_first   = r_first;
        n_status  = r_status;
        n_word    = r_word;
        n_clr_req = r_clr_req;
        case (r_state)
            pba_pkg::S_INIT: begin
                n_widx = last_word ? '0 : r_widx + WI'(1);
            end
            pba_pkg::S_IDLE: begin
                if (accept) begin
                    n_req     = i_req_type;
                    n_page    = req_page;
                    n_left    = i_page_count;
                    n_done    = '0;
                    n_first   = '0;
                    n_status  = pba_pkg::ST_OK;
                    n_clr_req = 1'b0;
                    case (i_req_type)
                        pba_pkg::REQ_ALLOC: begin
                            n_widx = '0;
                            if (i_page_count == '0) begin
                                n_status = pba_pkg::ST_NOFREE;
                            end
                        end
                        pba_pkg::REQ_GIVEN: begin
                            n_widx = req_page[pba_pkg::BIT_W +: WI];
                            if (!req_in_range) begin
                                n_status = pba_pkg::ST_RANGE;
                            end
                        end
                        pba_pkg::REQ_FREE: begin
                            n_widx = req_page[pba_pkg::BIT_W +: WI];
                            if (i_page_count == '0) begin
                                n_status = pba_pkg::ST_NOFREE;
                            end else if (!free_in_range) begin
                                n_status = pba_pkg::ST_RANGE;
                            end
                        end
                        default: begin
                            n_widx    = '0;
                            n_clr_req = 1'b1;
                        end
                    endcase
                end
            end
            pba_pkg::S_LOAD: begin
                n_word = r_rdata;
            end
            pba_pkg::S_ALLOC: begin
                if (fz.found) begin
                    n_word = r_word | fz.onehot;
                    n_done = r_done + pba_pkg::CNT_W'(1);
                    n_left = r_left - pba_pkg::CNT_W'(1);
                    if (r_done == '0) begin
                        n_first = alloc_page[pba_pkg::IDX_W-1:0];
                    end
                end else if (last_word) begin
                    n_status = pba_pkg::ST_NOFREE;
                end else begin
                    n_widx = r_widx + WI'(1);
                end
            end
            pba_pkg::S_GIVEN: begin
                if (page_set) begin
                    n_status = pba_pkg::ST_STATE;
                end else begin
                    n_done = pba_pkg::CNT_W'(1);
                end
            end
            pba_pkg::S_FREE: begin
                if (!page_set) begin
                    n_status = pba_pkg::ST_STATE;
                end else begin
                    n_word = r_word & ~page_bit;
                    n_done = r_done + pba_pkg::CNT_W'(1);
                    n_left = r_left - pba_pkg::CNT_W'(1);
                    n_page = next_page;
                    if (!last_one && word_end) begin
                        if (next_page >= TOTAL_PG) begin
                            n_status = pba_pkg::ST_RANGE;
                        end else begin
                            n_widx = next_page[pba_pkg::BIT_W +: WI];
                        end
                    end
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pba_pkg::S_INIT;
            r_widx    <= '0;
            r_clr_req <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_widx    <= n_widx;
            r_clr_req <= n_clr_req;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_page   <= n_page;
        r_left   <= n_left;
        r_done   <= n_done;
        r_first  <= n_first;
        r_status <= n_status;
        r_word   <= n_word;
    end

    // bitmap memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[r_widx];
    end

    // a result beat lasts exactly one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for more than one cycle");

    // an accepted request keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after taking a request");

    // only allocate-count reports a first page
    a_first_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_first_page != '0)) |-> (r_req == pba_pkg::REQ_ALLOC))
        else $error("first page reported on a request other than allocate-count");

    // memory reads stay inside the bitmap
    a_read_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pba_pkg::S_RD) |-> ({1'b0, r_widx} < (WI + 1)'(BITMAP_WORDS)))
        else $error("bitmap read beyond last word");

    // given-page success always reports exactly one page
    a_given_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (r_req == pba_pkg::REQ_GIVEN) && (o_status == pba_pkg::ST_OK))
        |-> (o_pages_done == pba_pkg::CNT_W'(1)))
        else $error("allocate-given success without one page done");

endmodule

>>> bench/pba_checker.sv
// result checker for the page bitmap allocator: tracks page ownership and compares beats
`timescale 1ns / 1ps

module pba_checker #(
    parameter int unsigned BITMAP_WORDS   = 16,
    parameter int unsigned RESERVED_PAGES = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  logic [pba_pkg::REQ_W-1:0]    i_req_type,
    input  logic [pba_pkg::IDX_W-1:0]    i_page_index,
    input  logic [pba_pkg::CNT_W-1:0]    i_page_count,
    input  logic                         i_strobe,
    input  logic [pba_pkg::STAT_W-1:0]   i_status,
    input  logic [pba_pkg::IDX_W-1:0]    i_first_page,
    input  logic [pba_pkg::CNT_W-1:0]    i_pages_done,
    output int                           o_errors,
    output int                           o_pending
);

    localparam int unsigned PAGES = BITMAP_WORDS * pba_pkg::WORD_BITS;

    typedef struct packed {
        logic [pba_pkg::STAT_W-1:0] status;
        logic [pba_pkg::IDX_W-1:0]  first_page;
        logic [pba_pkg::CNT_W-1:0]  pages_done;
    } t_answer;

    // one bit per page, set when taken
    logic [PAGES-1:0] page_used;
    t_answer          pending_answers[$];
    int               errors = 0;
    int               pending = 0;

    assign o_errors  = errors;
    assign o_pending = pending;

    // empty table with only the reserved low pages taken
    function automatic void reset_pages();
        page_used = '0;
        for (int unsigned p = 0; p < RESERVED_PAGES && p < pba_pkg::WORD_BITS; p++) begin
            page_used[p] = 1'b1;
        end
    endfunction

    // apply one request to the page table and work out its answer
    function automatic t_answer serve_request(
        input logic [pba_pkg::REQ_W-1:0] kind,
        input logic [pba_pkg::IDX_W-1:0] idx,
        input logic [pba_pkg::CNT_W-1:0] cnt
    );
        t_answer     ans;
        int unsigned scan;
        int unsigned pg;
        bit          stop;
        ans  = '0;
        scan = 0;
        stop = 1'b0;
        case (kind)
            pba_pkg::REQ_ALLOC: begin
                if (cnt == 0) begin
                    ans.status = pba_pkg::ST_NOFREE;
                end else begin
                    // lowest free page only moves up within one request
                    for (int unsigned n = 0; n < cnt && !stop; n++) begin
                        while (scan < PAGES && page_used[scan]) scan++;
                        if (scan >= PAGES) begin
                            ans.status = pba_pkg::ST_NOFREE;
                            stop       = 1'b1;
                        end else begin
                            page_used[scan] = 1'b1;
                            if (ans.pages_done == 0) begin
                                ans.first_page = pba_pkg::IDX_W'(scan);
                            end
                            ans.pages_done = ans.pages_done + pba_pkg::CNT_W'(1);
                        end
                    end
                end
            end
            pba_pkg::REQ_GIVEN: begin
                if (idx >= PAGES) begin
                    ans.status = pba_pkg::ST_RANGE;
                end else if (page_used[idx]) begin
                    ans.status = pba_pkg::ST_STATE;
                end else begin
                    page_used[idx] = 1'b1;
                    ans.pages_done = pba_pkg::CNT_W'(1);
                end
            end
            pba_pkg::REQ_FREE: begin
                if (cnt == 0) begin
                    ans.status = pba_pkg::ST_NOFREE;
                end else begin
                    for (int unsigned n = 0; n < cnt && !stop; n++) begin
                        pg = idx + n;
                        if (pg < RESERVED_PAGES || pg >= PAGES) begin
                            ans.status = pba_pkg::ST_RANGE;
                            stop       = 1'b1;
                        end else if (!page_used[pg]) begin
                            ans.status = pba_pkg::ST_STATE;
                            stop       = 1'b1;
                        end else begin
                            page_used[pg]  = 1'b0;
                            ans.pages_done = ans.pages_done + pba_pkg::CNT_W'(1);
                        end
                    end
                end
            end
            pba_pkg::REQ_CLEAR: begin
                reset_pages();
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    // report one result field that differs from the prediction
    task automatic check_field(input string name, input logic [pba_pkg::CNT_W-1:0] want,
                               input logic [pba_pkg::CNT_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // compare result beats, then predict accepted request beats
    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            reset_pages();
            pending_answers.delete();
        end else begin
            if (i_strobe) begin
                if (pending_answers.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with nothing expected, actual %0d/%0d/%0d",
                             $time, i_status, i_first_page, i_pages_done);
                end else begin
                    want = pending_answers.pop_front();
                    check_field("status", pba_pkg::CNT_W'(want.status),
                                pba_pkg::CNT_W'(i_status));
                    check_field("first_page", pba_pkg::CNT_W'(want.first_page),
                                pba_pkg::CNT_W'(i_first_page));
                    check_field("pages_done", want.pages_done, i_pages_done);
                end
            end
            if (i_start && !i_busy) begin
                pending_answers.push_back(serve_request(i_req_type, i_page_index,
                                                        i_page_count));
            end
        end
        pending = pending_answers.size();
    end

endmodule

>>> bench/tb_page_bitmap_allocator.sv
// testbench top for the page bitmap allocator: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module tb_page_bitmap_allocator;

    localparam int unsigned BITMAP_WORDS   = 16;
    localparam int unsigned RESERVED_PAGES = 2;
    localparam int unsigned RANDOM_ITEMS   = 1450;
    localparam int unsigned TAIL_CYCLES    = 20;
    localparam longint      CYCLE_LIMIT    = 4000000;

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       start        = 1'b0;
    logic [pba_pkg::REQ_W-1:0]  i_req_type   = '0;
    logic [pba_pkg::IDX_W-1:0]  i_page_index = '0;
    logic [pba_pkg::CNT_W-1:0]  i_page_count = '0;
    logic                       busy;
    logic                       o_strobe;
    logic [pba_pkg::STAT_W-1:0] o_status;
    logic [pba_pkg::IDX_W-1:0]  o_first_page;
    logic [pba_pkg::CNT_W-1:0]  o_pages_done;
    int                         errors;
    int                         pending;
    longint                     cycles = 0;

    page_bitmap_allocator #(
        .BITMAP_WORDS  (BITMAP_WORDS),
        .RESERVED_PAGES(RESERVED_PAGES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req_type  (i_req_type),
        .i_page_index(i_page_index),
        .i_page_count(i_page_count),
        .o_strobe    (o_strobe),
        .o_status    (o_status),
        .o_first_page(o_first_page),
        .o_pages_done(o_pages_done)
    );

    pba_checker #(
        .BITMAP_WORDS  (BITMAP_WORDS),
        .RESERVED_PAGES(RESERVED_PAGES)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_req_type  (i_req_type),
        .i_page_index(i_page_index),
        .i_page_count(i_page_count),
        .i_strobe    (o_strobe),
        .i_status    (o_status),
        .i_first_page(o_first_page),
        .i_pages_done(o_pages_done),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("page_bitmap_allocator test failed");
            $finish;
        end
    end

    // drive one request beat and hold it until accepted
    task automatic send_req(input logic [pba_pkg::REQ_W-1:0] kind,
                            input logic [pba_pkg::IDX_W-1:0] idx,
                            input logic [pba_pkg::CNT_W-1:0] cnt);
        int unsigned gap;
        bit          wait_idle;
        gap       = $urandom_range(0, 4);
        wait_idle = ($urandom_range(0, 3) == 0);
        @(negedge i_clk);
        if (wait_idle || gap != 0) begin
            // idle with junk on the fields
            start        <= 1'b0;
            i_req_type   <= pba_pkg::REQ_W'($urandom);
            i_page_index <= pba_pkg::IDX_W'($urandom);
            i_page_count <= pba_pkg::CNT_W'($urandom);
        end
        if (wait_idle) begin
            do @(posedge i_clk); while (busy);
            @(negedge i_clk);
        end
        repeat (gap) @(negedge i_clk);
        start        <= 1'b1;
        i_req_type   <= kind;
        i_page_index <= idx;
        i_page_count <= cnt;
        do @(posedge i_clk); while (busy);
    endtask

    // random request, mostly small runs in the low pages where allocations live
    task automatic random_req();
        int unsigned               pick;
        int unsigned               spread;
        logic [pba_pkg::IDX_W-1:0] idx;
        logic [pba_pkg::CNT_W-1:0] cnt;
        pick   = $urandom_range(0, 99);
        spread = $urandom_range(0, 99);
        idx    = pba_pkg::IDX_W'($urandom_range(0, 95));
        cnt    = pba_pkg::CNT_W'($urandom_range(1, 8));
        if (pick < 35) begin
            if (spread < 5) cnt = pba_pkg::CNT_W'($urandom_range(0, 1023));
            else if (spread < 9) cnt = '0;
            send_req(pba_pkg::REQ_ALLOC, pba_pkg::IDX_W'($urandom), cnt);
        end else if (pick < 55) begin
            if (spread < 50) idx = pba_pkg::IDX_W'($urandom_range(0, 511));
            else idx = pba_pkg::IDX_W'($urandom_range(0, 63));
            send_req(pba_pkg::REQ_GIVEN, idx, pba_pkg::CNT_W'($urandom));
        end else if (pick < 95) begin
            if (spread < 30) idx = pba_pkg::IDX_W'($urandom_range(0, 511));
            if (spread % 20 == 0) cnt = pba_pkg::CNT_W'($urandom_range(0, 1023));
            else if (spread % 10 == 1) cnt = pba_pkg::CNT_W'($urandom_range(9, 64));
            send_req(pba_pkg::REQ_FREE, idx, cnt);
        end else begin
            send_req(pba_pkg::REQ_CLEAR, pba_pkg::IDX_W'($urandom),
                     pba_pkg::CNT_W'($urandom));
        end
    endtask

    initial begin
        // reset
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests
        send_req(pba_pkg::REQ_ALLOC, 9'd0,   10'd0);     // zero count allocate
        send_req(pba_pkg::REQ_FREE,  9'd5,   10'd0);     // zero count free
        send_req(pba_pkg::REQ_ALLOC, 9'd0,   10'd1);
        send_req(pba_pkg::REQ_GIVEN, 9'd0,   10'd0);     // reserved page already taken
        send_req(pba_pkg::REQ_GIVEN, 9'd511, 10'd0);
        send_req(pba_pkg::REQ_GIVEN, 9'd2,   10'd0);     // already taken
        send_req(pba_pkg::REQ_FREE,  9'd0,   10'd3);     // reserved start
        send_req(pba_pkg::REQ_FREE,  9'd1,   10'd1);
        send_req(pba_pkg::REQ_FREE,  9'd511, 10'd2);     // runs past the last page
        send_req(pba_pkg::REQ_FREE,  9'd300, 10'd1);     // not allocated
        send_req(pba_pkg::REQ_ALLOC, 9'd0,   10'd40);    // crosses a word boundary
        send_req(pba_pkg::REQ_FREE,  9'd10,  10'd100);   // stops at an unallocated page
        send_req(pba_pkg::REQ_GIVEN, 9'd511, 10'd0);
        send_req(pba_pkg::REQ_ALLOC, 9'd0,   10'd1023);  // runs out of pages
        send_req(pba_pkg::REQ_ALLOC, 9'd0,   10'd1);     // table full
        send_req(pba_pkg::REQ_GIVEN, 9'd200, 10'd0);
        send_req(pba_pkg::REQ_FREE,  9'd2,   10'd510);
        send_req(pba_pkg::REQ_FREE,  9'd511, 10'd1);
        send_req(pba_pkg::REQ_CLEAR, 9'd511, 10'd1023);
        send_req(pba_pkg::REQ_ALLOC, 9'd511, 10'd512);
        send_req(pba_pkg::REQ_FREE,  9'd256, 10'd1023);
        send_req(pba_pkg::REQ_CLEAR, 9'd0,   10'd0);
        send_req(pba_pkg::REQ_GIVEN, 9'd1,   10'd512);
        send_req(pba_pkg::REQ_FREE,  9'd511, 10'd512);
        send_req(pba_pkg::REQ_ALLOC, 9'd0,   10'd32);

        // random requests
        repeat (RANDOM_ITEMS) random_req();

        @(negedge i_clk);
        start <= 1'b0;

        // drain
        while (pending != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (errors == 0) begin
            $display("page_bitmap_allocator test passed");
        end else begin
            $display("page_bitmap_allocator test failed");
        end
        $finish;
    end

endmodule
